[design/sgs_pkg.sv]
// Shared types and constants for the sequence gap segmenter.
// Used by every module of the block; no dependencies of its own.
package sgs_pkg;

    // Default width of the length counters
    localparam int LEN_BITS_DEF = 40;
    localparam int GAPS_W = 32;
    localparam int CB_W = 20;
    localparam int SB_W = 21;

    // Input function codes
    localparam logic [1:0] FUNC_SYMBOL = 2'd0;
    localparam logic [1:0] FUNC_HEADER = 2'd1;
    localparam logic [1:0] FUNC_END = 2'd2;

    // Record kinds
    localparam logic [1:0] KIND_CONTIG = 2'd0;
    localparam logic [1:0] KIND_GAP = 2'd1;
    localparam logic [1:0] KIND_SCAFFOLD = 2'd2;

    // Unknown-base symbols and the header mark
    localparam logic [7:0] SYM_N_UPPER = 8'h4E;
    localparam logic [7:0] SYM_N_LOWER = 8'h6E;
    localparam logic [7:0] SYM_HEADER = 8'h3E;

    // Register indexes on the configuration port
    localparam logic REG_CONTIG_BREAK = 1'b0;
    localparam logic REG_SCAFFOLD_BREAK = 1'b1;
    localparam logic [CB_W-1:0] CB_RESET = 20'd9;
    localparam logic [SB_W-1:0] SB_RESET = {SB_W{1'b1}};

    // Result queue geometry
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    // Current configuration
    typedef struct packed {
        logic [CB_W-1:0] contig_break_len;
        logic [SB_W-1:0] scaffold_break_len;
    } sgs_cfg_t;

    // Records written into the queue in one cycle
    typedef struct packed {
        logic first;
        logic second;
    } sgs_push_t;

    // Queue status seen by the segmenting core
    typedef struct packed {
        logic room;
    } sgs_qstat_t;

endpackage

[design/sequence_gap_segmenter_top.sv]
// Top level of the sequence gap segmenter.
// Depends on sgs_pkg, sgs_regs, sgs_core and sgs_outq.
//
// Usage: sequence items arrive on the seq channel (seq_valid, seq_stall, func,
// symbol): func selects a sequence byte, a record header or the end of input.
// Records leave on the rec channel (rec_valid, rec_stall and the record fields),
// one record per request; last marks the final record caused by one item.
// The user is to write the break lengths over the APB-style port only while
// the block is idle; the block itself does not enforce this. An accepted item
// sits in the input register, is judged there, and its records enter the queue.
// Throughput: one item per cycle while the result queue has room for a pair.
// Items that close a contig or a scaffold make two records, and the output
// channel carries one record per cycle, so such items can fill the four-entry
// result queue; seq_stall then holds the input until there is room for a pair.
// Reset clears all counters and the queue and loads the break-length defaults.
// While the receiver stalls, records wait in the queue and seq_stall rises as
// soon as an item waits in the input register and the queue cannot take two
// more records.
module sequence_gap_segmenter_top
    import sgs_pkg::*;
#(
    parameter int LEN_BITS = LEN_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                seq_valid,
    output logic                seq_stall,
    input  logic [1:0]          func,
    input  logic [7:0]          symbol,
    output logic                rec_valid,
    input  logic                rec_stall,
    output logic [1:0]          record_kind,
    output logic [LEN_BITS-1:0] length,
    output logic [LEN_BITS-1:0] span_with_short_runs,
    output logic [LEN_BITS-1:0] contig_bases_sum,
    output logic [LEN_BITS-1:0] gap_bases,
    output logic [GAPS_W-1:0]   gap_total,
    output logic                last,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int REC_W = 3 + 4*LEN_BITS + GAPS_W;
    localparam int GB_LO = GAPS_W + 1;
    localparam int BS_LO = GB_LO + LEN_BITS;
    localparam int SP_LO = BS_LO + LEN_BITS;
    localparam int LN_LO = SP_LO + LEN_BITS;
    localparam int KD_LO = LN_LO + LEN_BITS;

    sgs_cfg_t         cfg;
    sgs_qstat_t       qstat;
    sgs_push_t        push;
    logic [REC_W-1:0] rec_first;
    logic [REC_W-1:0] rec_second;
    logic [REC_W-1:0] rec_data;

    sgs_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sgs_core #(
        .LEN_BITS (LEN_BITS),
        .REC_W    (REC_W)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .seq_valid  (seq_valid),
        .seq_stall  (seq_stall),
        .func       (func),
        .symbol     (symbol),
        .cfg        (cfg),
        .qstat      (qstat),
        .push       (push),
        .rec_first  (rec_first),
        .rec_second (rec_second)
    );

    sgs_outq #(
        .REC_W (REC_W)
    ) u_outq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .rec_first  (rec_first),
        .rec_second (rec_second),
        .qstat      (qstat),
        .rec_valid  (rec_valid),
        .rec_stall  (rec_stall),
        .rec_data   (rec_data)
    );

    // Unpack the record at the head of the queue
    assign record_kind = rec_data[KD_LO +: 2];
    assign length = rec_data[LN_LO +: LEN_BITS];
    assign span_with_short_runs = rec_data[SP_LO +: LEN_BITS];
    assign contig_bases_sum = rec_data[BS_LO +: LEN_BITS];
    assign gap_bases = rec_data[GB_LO +: LEN_BITS];
    assign gap_total = rec_data[1 +: GAPS_W];
    assign last = rec_data[0];

endmodule

[design/sgs_regs.sv]
// Configuration registers of the sequence gap segmenter on an APB-style port.
// Depends on sgs_pkg for register indexes, reset values and the config struct.
module sgs_regs
    import sgs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output sgs_cfg_t    cfg
);

    logic [CB_W-1:0] contig_break_len_reg;
    logic [SB_W-1:0] scaffold_break_len_reg;
    logic            wr_en;
    logic            reg_index;

    assign pready = 1'b1;
    assign wr_en = psel && penable && pwrite;
    assign reg_index = paddr[2];

    // Register writes in the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            contig_break_len_reg <= CB_RESET;
            scaffold_break_len_reg <= SB_RESET;
        end
        else if (wr_en)
        begin
            case (reg_index)
                REG_CONTIG_BREAK:
                begin
                    contig_break_len_reg <= pwdata[CB_W-1:0];
                end
                REG_SCAFFOLD_BREAK:
                begin
                    scaffold_break_len_reg <= pwdata[SB_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // Read-back mux
    always_comb
    begin
        case (reg_index)
            REG_CONTIG_BREAK:   prdata = {{(32-CB_W){1'b0}}, contig_break_len_reg};
            REG_SCAFFOLD_BREAK: prdata = {{(32-SB_W){1'b0}}, scaffold_break_len_reg};
            default:            prdata = 32'd0;
        endcase
    end

    assign cfg.contig_break_len = contig_break_len_reg;
    assign cfg.scaffold_break_len = scaffold_break_len_reg;

endmodule

[design/sgs_core.sv]
// Segmenting core: input register, run and contig tracking, record formation.
// Depends on sgs_pkg; feeds up to two packed records per cycle to sgs_outq.
module sgs_core
    import sgs_pkg::*;
#(
    parameter int LEN_BITS = LEN_BITS_DEF,
    parameter int REC_W = 3 + 4*LEN_BITS + GAPS_W
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             seq_valid,
    output logic             seq_stall,
    input  logic [1:0]       func,
    input  logic [7:0]       symbol,
    input  sgs_cfg_t         cfg,
    input  sgs_qstat_t       qstat,
    output sgs_push_t        push,
    output logic [REC_W-1:0] rec_first,
    output logic [REC_W-1:0] rec_second
);

    // Compare width wide enough for both the counters and the thresholds
    localparam int CW = (LEN_BITS > CB_W) ? LEN_BITS : CB_W;

    function automatic logic [LEN_BITS-1:0] sat_add(
        input logic [LEN_BITS-1:0] a,
        input logic [LEN_BITS-1:0] b,
        input logic                cin
    );
        logic [LEN_BITS:0] s;
        s = {1'b0, a} + {1'b0, b} + {{LEN_BITS{1'b0}}, cin};
        sat_add = s[LEN_BITS] ? {LEN_BITS{1'b1}} : s[LEN_BITS-1:0];
    endfunction

    function automatic logic [LEN_BITS-1:0] floor_sub(
        input logic [LEN_BITS-1:0] a,
        input logic [LEN_BITS-1:0] b
    );
        floor_sub = (a > b) ? (a - b) : {LEN_BITS{1'b0}};
    endfunction

    // Input register
    logic       in_full_reg, in_full_next;
    logic [1:0] func_reg;
    logic [7:0] symbol_reg;
    logic       accept;
    logic       advance;

    // Running state
    logic [LEN_BITS-1:0] run_len_reg, run_len_next;
    logic [LEN_BITS-1:0] contig_span_reg, contig_span_next;
    logic [LEN_BITS-1:0] contig_short_reg, contig_short_next;
    logic [LEN_BITS-1:0] scaf_total_reg, scaf_total_next;
    logic [LEN_BITS-1:0] scaf_bases_reg, scaf_bases_next;
    logic [LEN_BITS-1:0] scaf_span_reg, scaf_span_next;
    logic [GAPS_W-1:0]   scaf_gaps_reg, scaf_gaps_next;

    // Derived values
    logic [LEN_BITS-1:0] known;
    logic                scaf_empty;
    logic [LEN_BITS-1:0] drop;
    logic [LEN_BITS-1:0] bsum;
    logic [LEN_BITS-1:0] ssum;
    logic [LEN_BITS-1:0] tot;
    logic [LEN_BITS-1:0] gbases;
    logic                is_n;
    logic                sb_hit;
    logic                cb_hit;
    logic [GAPS_W-1:0]   gaps_inc;
    logic [LEN_BITS-1:0] one_len;
    logic [REC_W-1:0]    rec_contig;
    logic [REC_W-1:0]    rec_gap;
    logic [REC_W-1:0]    rec_scaf;
    logic                second_is_gap;

    // Input handshake: the register moves on when the queue can take two records
    assign advance = in_full_reg && qstat.room;
    assign seq_stall = in_full_reg && !qstat.room;
    assign accept = seq_valid && !seq_stall;

    always_comb
    begin
        if (accept)
        begin
            in_full_next = 1'b1;
        end
        else if (advance)
        begin
            in_full_next = 1'b0;
        end
        else
        begin
            in_full_next = in_full_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg <= func;
            symbol_reg <= symbol;
        end
    end

    // Shared arithmetic for closing a contig or scaffold
    assign one_len = {{(LEN_BITS-1){1'b0}}, 1'b1};
    assign known = floor_sub(contig_span_reg, contig_short_reg);
    assign scaf_empty = (scaf_gaps_reg == '0) && (known == '0);
    assign drop = (func_reg == FUNC_SYMBOL) ? run_len_reg : {LEN_BITS{1'b0}};
    assign bsum = sat_add(scaf_bases_reg, known, 1'b0);
    assign ssum = sat_add(scaf_span_reg, contig_span_reg, 1'b0);
    assign tot = floor_sub(scaf_total_reg, drop);
    assign gbases = floor_sub(tot, ssum);
    assign gaps_inc = (scaf_gaps_reg == {GAPS_W{1'b1}}) ? scaf_gaps_reg
                                                        : scaf_gaps_reg + 1'b1;

    // Run judgment against the two thresholds
    assign is_n = (symbol_reg == SYM_N_UPPER) || (symbol_reg == SYM_N_LOWER);
    assign sb_hit = !cfg.scaffold_break_len[SB_W-1] &&
                    (CW'(run_len_reg) == CW'(cfg.scaffold_break_len[SB_W-2:0]));
    assign cb_hit = CW'(run_len_reg) >= CW'(cfg.contig_break_len);

    // Record formats: kind, length, span, bases sum, gap bases, gap count, last
    assign rec_contig = {KIND_CONTIG, known, contig_span_reg, {LEN_BITS{1'b0}},
                         {LEN_BITS{1'b0}}, {GAPS_W{1'b0}}, 1'b0};
    assign rec_gap = {KIND_GAP, run_len_reg, {LEN_BITS{1'b0}}, {LEN_BITS{1'b0}},
                      {LEN_BITS{1'b0}}, {GAPS_W{1'b0}}, 1'b1};
    assign rec_scaf = {KIND_SCAFFOLD, tot, {LEN_BITS{1'b0}}, bsum, gbases,
                       scaf_gaps_reg, 1'b1};
    assign rec_first = rec_contig;
    assign rec_second = second_is_gap ? rec_gap : rec_scaf;

    // Next-state and record selection for the registered item
    always_comb
    begin
        run_len_next = run_len_reg;
        contig_span_next = contig_span_reg;
        contig_short_next = contig_short_reg;
        scaf_total_next = scaf_total_reg;
        scaf_bases_next = scaf_bases_reg;
        scaf_span_next = scaf_span_reg;
        scaf_gaps_next = scaf_gaps_reg;
        push = '0;
        second_is_gap = 1'b0;
        if (advance)
        begin
            case (func_reg)
                FUNC_HEADER, FUNC_END:
                begin
                    // Close the scaffold; a pending run stays in the total
                    push.first = !scaf_empty;
                    push.second = !scaf_empty;
                    run_len_next = '0;
                    contig_span_next = '0;
                    contig_short_next = '0;
                    scaf_total_next = '0;
                    scaf_bases_next = '0;
                    scaf_span_next = '0;
                    scaf_gaps_next = '0;
                end
                FUNC_SYMBOL:
                begin
                    if (is_n)
                    begin
                        run_len_next = sat_add(run_len_reg, '0, 1'b1);
                        scaf_total_next = sat_add(scaf_total_reg, '0, 1'b1);
                    end
                    else if ((run_len_reg != '0) && sb_hit)
                    begin
                        // Scaffold break: the run leaves the total
                        push.first = !scaf_empty;
                        push.second = !scaf_empty;
                        run_len_next = '0;
                        contig_span_next = one_len;
                        contig_short_next = '0;
                        scaf_total_next = one_len;
                        scaf_bases_next = '0;
                        scaf_span_next = '0;
                        scaf_gaps_next = '0;
                    end
                    else if ((run_len_reg != '0) && cb_hit)
                    begin
                        // Contig break: record a gap if the contig has bases
                        if (known != '0)
                        begin
                            push.first = 1'b1;
                            push.second = 1'b1;
                            second_is_gap = 1'b1;
                            scaf_bases_next = bsum;
                            scaf_span_next = ssum;
                            scaf_gaps_next = gaps_inc;
                        end
                        run_len_next = '0;
                        contig_span_next = one_len;
                        contig_short_next = '0;
                        scaf_total_next = sat_add(scaf_total_reg, '0, 1'b1);
                    end
                    else
                    begin
                        // Short or no run stays inside the contig
                        run_len_next = '0;
                        contig_span_next = sat_add(contig_span_reg, run_len_reg, 1'b1);
                        contig_short_next = sat_add(contig_short_reg, run_len_reg, 1'b0);
                        scaf_total_next = sat_add(scaf_total_reg, '0, 1'b1);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
            run_len_reg <= '0;
            contig_span_reg <= '0;
            contig_short_reg <= '0;
            scaf_total_reg <= '0;
            scaf_bases_reg <= '0;
            scaf_span_reg <= '0;
            scaf_gaps_reg <= '0;
        end
        else
        begin
            in_full_reg <= in_full_next;
            run_len_reg <= run_len_next;
            contig_span_reg <= contig_span_next;
            contig_short_reg <= contig_short_next;
            scaf_total_reg <= scaf_total_next;
            scaf_bases_reg <= scaf_bases_next;
            scaf_span_reg <= scaf_span_next;
            scaf_gaps_reg <= scaf_gaps_next;
        end
    end

`ifndef SYNTHESIS
    // Records always come in pairs, so the second never goes out alone.
    assert property (@(posedge clk) disable iff (!rst_n)
        push.second |-> push.first)
        else $error("second record pushed without the first");

    // An unknown base always leaves a pending run behind.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (func_reg == FUNC_SYMBOL) && is_n) |=> (run_len_reg != '0))
        else $error("unknown base did not extend the run");

    // Nothing is pushed unless the registered item moves on.
    assert property (@(posedge clk) disable iff (!rst_n)
        push.first |-> advance)
        else $error("record pushed without an item");
`endif

endmodule

[design/sgs_outq.sv]
// Result queue: takes up to two records a cycle and hands out one a cycle while rec_stall is low.
// Depends on sgs_pkg for queue geometry and the push and status structs.
module sgs_outq
    import sgs_pkg::*;
#(
    parameter int REC_W = 3 + 4*LEN_BITS_DEF + GAPS_W
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  sgs_push_t        push,
    input  logic [REC_W-1:0] rec_first,
    input  logic [REC_W-1:0] rec_second,
    output sgs_qstat_t       qstat,
    output logic             rec_valid,
    input  logic             rec_stall,
    output logic [REC_W-1:0] rec_data
);

    logic [REC_W-1:0]  mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic [QPTR_W-1:0] wr_ptr_second;
    logic              pop;

    assign rec_valid = (count_reg != '0);
    assign rec_data = mem_reg[rd_ptr_reg];
    assign pop = rec_valid && !rec_stall;
    assign qstat.room = (count_reg <= QCNT_W'(QDEPTH - 2));
    assign wr_ptr_second = wr_ptr_reg + 1'b1;

    // Pointer and fill bookkeeping
    assign wr_ptr_next = wr_ptr_reg + QPTR_W'(push.first) + QPTR_W'(push.second);
    assign rd_ptr_next = rd_ptr_reg + QPTR_W'(pop);
    assign count_next = count_reg + QCNT_W'(push.first) + QCNT_W'(push.second)
                        - QCNT_W'(pop);

    // Record storage
    always_ff @(posedge clk)
    begin
        if (push.first)
        begin
            mem_reg[wr_ptr_reg] <= rec_first;
        end
        if (push.second)
        begin
            mem_reg[wr_ptr_second] <= rec_second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

`ifndef SYNTHESIS
    // The fill level never passes the depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QDEPTH))
        else $error("result queue overflow");

    // A push only happens while two free slots remain.
    assert property (@(posedge clk) disable iff (!rst_n)
        push.first |-> qstat.room)
        else $error("push without room");

    // An empty queue has equal read and write pointers.
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with unequal pointers");
`endif

endmodule
